// ----- design/pmt_pkg.sv -----
// Shared types, constants and the stream type classifier for the PMT entry parser.
package pmt_pkg;

  localparam int unsigned PMT_FIFO_DEPTH = 2;

  localparam logic [12:0] PMT_POS_MAX      = 13'h1FFF;
  localparam logic [12:0] PMT_HEADER_BYTES = 13'd12;

  // One elementary stream entry as it leaves the block.
  typedef struct packed {
    logic [7:0]  es_type;
    logic [12:0] elementary_pid;
    logic [11:0] desc_len;
    logic [15:0] prog_num;
    logic [12:0] pcr_pid;
    logic [4:0]  sect_version;
  } pmt_result_t;

  // True for the stream types that produce an output item.
  function automatic logic pmt_type_known(input logic [7:0] t);
    logic known;
    known = 1'b0;
    case (t) inside
      [8'h00:8'h1E], 8'h20, 8'h24, 8'h42, 8'h7F, [8'h80:8'h86], 8'h90, 8'h92, 8'h93,
      [8'h99:8'h9B], 8'hA1, 8'hA2, 8'hEA, [8'hF0:8'hF2], 8'hFF: known = 1'b1;
      default: known = 1'b0;
    endcase
    return known;
  endfunction

endpackage

// ----- design/pmt_front.sv -----
// Front end: tracks section position, captures header fields and classifies entries.
module pmt_front import pmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  section_byte_i,
  input  logic        section_first_i,
  output logic        push_o,
  output pmt_result_t result_o
);

  localparam logic [12:0] PosLenHi   = 13'd1;
  localparam logic [12:0] PosLenLo   = 13'd2;
  localparam logic [12:0] PosProgHi  = 13'd3;
  localparam logic [12:0] PosProgLo  = 13'd4;
  localparam logic [12:0] PosVersion = 13'd5;
  localparam logic [12:0] PosPcrHi   = 13'd8;
  localparam logic [12:0] PosPcrLo   = 13'd9;
  localparam logic [12:0] PosInfoHi  = 13'd10;
  localparam logic [12:0] PosInfoLo  = 13'd11;

  logic [12:0] pos_q, pos_d;
  logic        active_q, active_d;
  logic [11:0] section_len_q, section_len_d;
  logic [3:0]  info_len_hi_q, info_len_hi_d;
  logic [12:0] entry_start_q, entry_start_d;
  logic [7:0]  entry_type_q, entry_type_d;
  logic [12:0] entry_pid_q, entry_pid_d;
  logic [3:0]  es_len_hi_q, es_len_hi_d;
  logic [15:0] program_num_q, program_num_d;
  logic [12:0] pcr_pid_q, pcr_pid_d;
  logic [4:0]  version_q, version_d;

  logic [12:0] pos;
  logic        step;
  logic [11:0] limit;
  logic        in_entry;
  logic [12:0] off;
  logic [11:0] es_len;
  logic [13:0] next_start;

  assign pos    = section_first_i ? 13'd0 : pos_q;
  assign step   = accept_i && (section_first_i || active_q);
  assign limit  = (section_len_q == 12'd0) ? 12'd0 : section_len_q - 12'd1;
  assign in_entry = (pos >= PMT_HEADER_BYTES) && (entry_start_q < {1'b0, limit})
                 && (pos >= entry_start_q);
  assign off    = pos - entry_start_q;
  assign es_len = {es_len_hi_q, section_byte_i};
  assign next_start = {1'b0, entry_start_q} + 14'd5 + {2'b00, es_len};

  always_comb begin
    pos_d         = pos_q;
    active_d      = active_q;
    section_len_d = section_len_q;
    info_len_hi_d = info_len_hi_q;
    entry_start_d = entry_start_q;
    entry_type_d  = entry_type_q;
    entry_pid_d   = entry_pid_q;
    es_len_hi_d   = es_len_hi_q;
    program_num_d = program_num_q;
    pcr_pid_d     = pcr_pid_q;
    version_d     = version_q;
    push_o        = 1'b0;
    if (step) begin
      active_d = 1'b1;
      pos_d    = (pos == PMT_POS_MAX) ? pos : pos + 13'd1;
      unique case (pos)
        PosLenHi:   section_len_d = {section_byte_i[3:0], 8'h00};
        PosLenLo:   section_len_d = {section_len_q[11:8], section_byte_i};
        PosProgHi:  program_num_d = {section_byte_i, 8'h00};
        PosProgLo:  program_num_d = {program_num_q[15:8], section_byte_i};
        PosVersion: version_d     = section_byte_i[5:1];
        PosPcrHi:   pcr_pid_d     = {section_byte_i[4:0], 8'h00};
        PosPcrLo:   pcr_pid_d     = {pcr_pid_q[12:8], section_byte_i};
        PosInfoHi:  info_len_hi_d = section_byte_i[3:0];
        PosInfoLo:  entry_start_d = PMT_HEADER_BYTES + {1'b0, info_len_hi_q, section_byte_i};
        default: ;
      endcase
      if (in_entry) begin
        unique case (off)
          13'd0: entry_type_d = section_byte_i;
          13'd1: entry_pid_d  = {section_byte_i[4:0], 8'h00};
          13'd2: entry_pid_d  = {entry_pid_q[12:8], section_byte_i};
          13'd3: es_len_hi_d  = section_byte_i[3:0];
          13'd4: begin
            push_o        = pmt_type_known(entry_type_q);
            entry_start_d = next_start[13] ? PMT_POS_MAX : next_start[12:0];
          end
          default: ;
        endcase
      end
    end
  end

  assign result_o.es_type        = entry_type_q;
  assign result_o.elementary_pid = entry_pid_q;
  assign result_o.desc_len       = es_len;
  assign result_o.prog_num       = program_num_q;
  assign result_o.pcr_pid        = pcr_pid_q;
  assign result_o.sect_version   = version_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      active_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      active_q <= active_d;
    end
  end

  // Header and entry fields are always written before they are used.
  always_ff @(posedge clk_i) begin
    section_len_q <= section_len_d;
    info_len_hi_q <= info_len_hi_d;
    entry_start_q <= entry_start_d;
    entry_type_q  <= entry_type_d;
    entry_pid_q   <= entry_pid_d;
    es_len_hi_q   <= es_len_hi_d;
    program_num_q <= program_num_d;
    pcr_pid_q     <= pcr_pid_d;
    version_q     <= version_d;
  end

endmodule

// ----- design/pmt_queue.sv -----
// Back end: result queue that holds entries until the output side takes them.
module pmt_queue import pmt_pkg::*; #(
  parameter int unsigned Depth = PMT_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  pmt_result_t data_i,
  output logic        full_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pmt_result_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  pmt_result_t     mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign full_o      = (count_q == CntFull);
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign data_o      = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- design/pmt_stream_entry_parser.sv -----
// Top level of the program map section entry parser.
// With no earlier result waiting, a result item is offered in the cycle after the entry's fifth byte is accepted.
// Throughput: one section byte per cycle; the front accepts whenever the result queue
// has a free slot, so the queue depth sets how long the output side may stall.
// Reset: rst_ni is asynchronous and active low; it closes any open section and
// empties the result queue. No clearing pass is needed after reset.
module pmt_stream_entry_parser import pmt_pkg::*; #(
  parameter int unsigned FifoDepth = PMT_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  section_byte_i,
  input  logic        section_first_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  es_type_o,
  output logic [12:0] elementary_pid_o,
  output logic [11:0] desc_len_o,
  output logic [15:0] prog_num_o,
  output logic [12:0] pcr_pid_o,
  output logic [4:0]  sect_version_o
);

  logic        queue_full;
  logic        accept;
  logic        push;
  pmt_result_t front_result;
  pmt_result_t out_result;

  // The front never waits on the output directly: it only needs room in the
  // queue for the one result that an item can produce.
  assign in_ready_o = !queue_full;
  assign accept     = in_valid_i && in_ready_o;

  // The front walks the header and the elementary stream entries, and flags
  // an item for the queue when an entry of a recognized type completes.
  pmt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .section_byte_i  (section_byte_i),
    .section_first_i (section_first_i),
    .push_o          (push),
    .result_o        (front_result)
  );

  // The back end holds finished entries and presents them on the output port.
  pmt_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (front_result),
    .full_o      (queue_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (out_result)
  );

  assign es_type_o        = out_result.es_type;
  assign elementary_pid_o = out_result.elementary_pid;
  assign desc_len_o       = out_result.desc_len;
  assign prog_num_o       = out_result.prog_num;
  assign pcr_pid_o        = out_result.pcr_pid;
  assign sect_version_o   = out_result.sect_version;

endmodule

// ----- design/pmt_checker.sv -----
// Port-level checks for the PMT entry parser, bound to the top level.
module pmt_checker import pmt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  section_byte_i,
  input logic        section_first_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  es_type_o,
  input logic [12:0] elementary_pid_o,
  input logic [11:0] desc_len_o,
  input logic [15:0] prog_num_o,
  input logic [12:0] pcr_pid_o,
  input logic [4:0]  sect_version_o
);

  // A stalled output item holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(es_type_o)
      && $stable(elementary_pid_o) && $stable(desc_len_o))
    else $error("stalled output item changed");

  // Only recognized stream types leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pmt_type_known(es_type_o))
    else $error("unrecognized stream type on output");

  // Input back-pressure only happens while results are waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // A new result appears only right after an accepted input item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result appeared without an accepted item");

endmodule

bind pmt_stream_entry_parser pmt_checker u_pmt_checker (.*);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the program map section entry parser.
module tb_top;
  import pmt_pkg::*;

  // The section ends in a 4-byte CRC. The limit on results is the CRC start.
  localparam int RANDOM_ITEMS = 1100;
  // Results reach the output through the result queue after the fifth entry
  // byte, so the slack after the last result is plenty.
  localparam int DRAIN_SLACK = 8;

  typedef struct {
    logic [7:0]  data;
    logic        first;
    bit          typed;
    pmt_result_t want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  sec_byte = 8'h00;
  logic        sec_first = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  got_type;
  logic [12:0] got_pid;
  logic [11:0] got_es_len;
  logic [15:0] got_program;
  logic [12:0] got_pcr;
  logic [4:0]  got_version;

  // Predicted parser state. It mirrors the block's view of the open section.
  logic        in_section = 1'b0;
  logic [12:0] parse_pos = '0;
  logic [11:0] parse_len = '0;
  logic [11:0] info_len = '0;
  logic [12:0] entry_pos = '0;
  logic [7:0]  ent_type = '0;
  logic [12:0] ent_pid = '0;
  logic [3:0]  ent_len_hi = '0;
  logic [15:0] hdr_program = '0;
  logic [12:0] hdr_pcr = '0;
  logic [4:0]  hdr_version = '0;

  pmt_result_t entries_due[$];
  int          fail_count = 0;
  int          parsed_items = 0;
  bit          steady_in = 1'b0;

  pmt_stream_entry_parser DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .section_byte_i   (sec_byte),
    .section_first_i  (sec_first),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .es_type_o        (got_type),
    .elementary_pid_o (got_pid),
    .desc_len_o       (got_es_len),
    .prog_num_o       (got_program),
    .pcr_pid_o        (got_pcr),
    .sect_version_o   (got_version)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Stream types for which an entry produces an item.
  function automatic bit type_recognized(logic [7:0] t);
    if (t <= 8'h1E || (t >= 8'h80 && t <= 8'h86) || (t >= 8'h99 && t <= 8'h9B) ||
        (t >= 8'hF0 && t <= 8'hF2)) begin
      return 1'b1;
    end
    case (t)
      8'h20, 8'h24, 8'h42, 8'h7F, 8'h90, 8'h92, 8'h93, 8'hA1, 8'hA2, 8'hEA, 8'hFF: begin
        return 1'b1;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  // Advances the predicted parser by one section byte. The seen flag tells
  // whether the byte fell inside an open section; hit tells whether it
  // completed an entry of a recognized type.
  task automatic predict_byte(input logic [7:0] b, input logic f, output bit seen,
                              output bit hit, output pmt_result_t res);
    int unsigned lim;
    int unsigned off;
    int unsigned es_len;
    int unsigned nxt;
    seen = 1'b0;
    hit = 1'b0;
    res = '0;
    if (f) begin
      in_section = 1'b1;
      parse_pos = '0;
    end
    if (!in_section) begin
      return;
    end
    seen = 1'b1;
    case (parse_pos)
      13'd1: parse_len = {b[3:0], 8'h00};
      13'd2: parse_len[7:0] = b;
      13'd3: hdr_program = {b, 8'h00};
      13'd4: hdr_program[7:0] = b;
      13'd5: hdr_version = b[5:1];
      13'd8: hdr_pcr = {b[4:0], 8'h00};
      13'd9: hdr_pcr[7:0] = b;
      13'd10: info_len = {b[3:0], 8'h00};
      13'd11: begin
        info_len[7:0] = b;
        entry_pos = PMT_HEADER_BYTES + 13'(info_len);
      end
      default: ;
    endcase
    if (parse_pos >= PMT_HEADER_BYTES) begin
      // Entries are read only when they start before the CRC, but an entry
      // that has started is always read to its fifth byte.
      lim = (parse_len >= 12'd1) ? parse_len - 1 : 0;
      if (entry_pos < lim && parse_pos >= entry_pos) begin
        off = 32'(parse_pos - entry_pos);
        case (off)
          0: ent_type = b;
          1: ent_pid = {b[4:0], 8'h00};
          2: ent_pid[7:0] = b;
          3: ent_len_hi = b[3:0];
          4: begin
            es_len = 32'({ent_len_hi, b});
            if (type_recognized(ent_type)) begin
              hit = 1'b1;
              res.es_type = ent_type;
              res.elementary_pid = ent_pid;
              res.desc_len = es_len[11:0];
              res.prog_num = hdr_program;
              res.pcr_pid = hdr_pcr;
              res.sect_version = hdr_version;
            end
            // The next entry start saturates past any possible limit.
            nxt = entry_pos + 5 + es_len;
            entry_pos = (nxt > PMT_POS_MAX) ? PMT_POS_MAX : nxt[12:0];
          end
          default: ;
        endcase
      end
    end
    if (parse_pos < PMT_POS_MAX) begin
      parse_pos = parse_pos + 13'd1;
    end
  endtask

  // Mostly back-to-back items, some short gaps and a few long ones.
  function automatic int pick_gap();
    int r;
    if (steady_in) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  // Offers one byte, waits for it to be taken and records what it should cause.
  // Readiness is sampled on the falling edge, where it is stable for the next
  // rising edge. The task returns in the time step of the accepting edge.
  task automatic feed_byte(input logic [7:0] b, input logic f, input bit typed = 1'b0,
                           input pmt_result_t want = '0);
    int          gap;
    bit          seen;
    bit          hit;
    pmt_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    sec_byte <= b;
    sec_first <= f;
    @(negedge clk_i);
    while (in_ready !== 1'b1) @(negedge clk_i);
    @(posedge clk_i);
    predict_byte(b, f, seen, hit, res);
    if (seen) begin
      parsed_items++;
    end
    if (typed) begin
      entries_due.insert(entries_due.size(), want);
    end else if (hit) begin
      entries_due.insert(entries_due.size(), res);
    end
  endtask

  // Holds the sender off until every predicted item has been seen.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (entries_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Receiver side: ready runs of random length broken by stalls, most short.
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      stall = $urandom_range(0, 99);
      if (stall < 70) begin
        stall = $urandom_range(1, 3);
      end else if (stall < 95) begin
        stall = $urandom_range(4, 10);
      end else begin
        stall = $urandom_range(20, 40);
      end
      out_ready <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
  end

  // Result checker. An item moves at the next rising edge when valid and ready
  // are both high on the falling edge before it.
  always @(negedge clk_i) begin
    pmt_result_t exp_item;
    if (rst_ni === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (entries_due.size() == 0) begin
        $error("unexpected result item: es_type 0x%0h pid 0x%0h", got_type, got_pid);
        fail_count++;
      end else begin
        exp_item = entries_due.pop_front();
        check_field("es_type", 32'(exp_item.es_type), 32'(got_type));
        check_field("elementary_pid", 32'(exp_item.elementary_pid), 32'(got_pid));
        check_field("desc_len", 32'(exp_item.desc_len), 32'(got_es_len));
        check_field("prog_num", 32'(exp_item.prog_num), 32'(got_program));
        check_field("pcr_pid", 32'(exp_item.pcr_pid), 32'(got_pcr));
        check_field("sect_version", 32'(exp_item.sect_version), 32'(got_version));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    plan_row_t   plan[$];
    pmt_result_t all_ones;
    logic [7:0]  frame[$];
    logic [7:0]  body[$];
    bit          marks[$];
    logic [31:0] r;
    logic [7:0]  typ;
    int          kind;
    int          n;
    int          info;
    int          slen;
    int          pnum;
    int          ver;
    int          pcr;
    int          pid;
    int          es;
    int          cut;

    all_ones = '{es_type: 8'hFF, elementary_pid: 13'h1FFF, desc_len: 12'hFFF,
                 prog_num: 16'hFFFF, pcr_pid: 13'h1FFF, sect_version: 5'h1F};

    // Directed part. Two stray bytes come before any section and are dropped.
    plan.insert(plan.size(), '{8'hFF, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'h00, 1'b0, 1'b0, '0});
    // A section with program number, version and PCR PID at their maximum and
    // section_len = 14, so the CRC starts at byte 13: the one entry starts
    // before it and runs into the CRC, yet is still read to its end.
    plan.insert(plan.size(), '{8'h02, 1'b1, 1'b0, '0});
    plan.insert(plan.size(), '{8'hF0, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'h0E, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'hFF, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'hFF, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'hFF, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'h00, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'h00, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'hFF, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'hFF, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'hF0, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'h00, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'hFF, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'hFF, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'hFF, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'hFF, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'hFF, 1'b0, 1'b1, all_ones});
    // Bytes past the last entry are ignored until the next section starts.
    plan.insert(plan.size(), '{8'h1B, 1'b0, 1'b0, '0});
    plan.insert(plan.size(), '{8'h00, 1'b0, 1'b0, '0});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      feed_byte(plan[i].data, plan[i].first, plan[i].typed, plan[i].want);
    end
    wait_drained();

    // Random part: mostly well-formed sections with random content, plus
    // sections with a wrong length, cut-off sections and plain noise.
    parsed_items = 0;
    while (parsed_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      steady_in = ($urandom_range(0, 4) == 0);
      frame.delete();
      marks.delete();
      if (kind == 9) begin
        n = $urandom_range(1, 20);
        repeat (n) begin
          r = $urandom;
          frame.insert(frame.size(), r[7:0]);
          marks.insert(marks.size(), r[10:8] == 3'd0);
        end
      end else begin
        info = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        body.delete();
        n = $urandom_range(0, 5);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            typ = 8'($urandom_range(0, 255));
          end else begin
            do typ = 8'($urandom_range(0, 255)); while (!type_recognized(typ));
          end
          pid = $urandom_range(0, 8191);
          es = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 4);
          r = $urandom;
          body.insert(body.size(), typ);
          body.insert(body.size(), {r[2:0], pid[12:8]});
          body.insert(body.size(), pid[7:0]);
          body.insert(body.size(), {r[6:3], es[11:8]});
          body.insert(body.size(), es[7:0]);
          repeat (es) begin
            r = $urandom;
            body.insert(body.size(), r[7:0]);
          end
        end
        slen = 9 + info + body.size() + 4;
        if (kind == 7) begin
          case ($urandom_range(0, 2))
            0: slen = 0;
            1: slen = 1;
            default: slen = $urandom_range(0, slen + 6);
          endcase
        end
        pnum = $urandom_range(0, 65535);
        ver = $urandom_range(0, 31);
        pcr = $urandom_range(0, 8191);
        r = $urandom;
        // The table identifier, section number and last section number are
        // never checked.
        frame.insert(frame.size(), r[7:0]);
        frame.insert(frame.size(), {r[11:8], slen[11:8]});
        frame.insert(frame.size(), slen[7:0]);
        frame.insert(frame.size(), pnum[15:8]);
        frame.insert(frame.size(), pnum[7:0]);
        frame.insert(frame.size(), {r[13:12], ver[4:0], r[14]});
        frame.insert(frame.size(), r[23:16]);
        frame.insert(frame.size(), r[31:24]);
        r = $urandom;
        frame.insert(frame.size(), {r[2:0], pcr[12:8]});
        frame.insert(frame.size(), pcr[7:0]);
        frame.insert(frame.size(), {r[6:3], info[11:8]});
        frame.insert(frame.size(), info[7:0]);
        repeat (info + 4) begin
          r = $urandom;
          frame.insert(frame.size(), r[7:0]);
        end
        // The program descriptors go ahead of the entries and the CRC after.
        for (int i = 0; i < 4; i++) begin
          body.insert(body.size(), frame.pop_back());
        end
        foreach (body[i]) begin
          frame.insert(frame.size(), body[i]);
        end
        if (kind < 7 && $urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            r = $urandom;
            frame.insert(frame.size(), r[7:0]);
          end
        end
        if (kind == 8) begin
          cut = $urandom_range(1, frame.size());
          while (frame.size() > cut) void'(frame.pop_back());
        end
      end
      foreach (frame[i]) begin
        feed_byte(frame[i], (kind == 9) ? marks[i] : (i == 0));
      end
    end
    steady_in = 1'b0;
    wait_drained();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
